/* src/upst_pkg.sv */
// Shared types and constants for the unigram power sampling table unit.
// No dependencies; the files that use it refer to this package by scoped names.
package upst_pkg;

    localparam int VOCAB_DEPTH_DEF = 4096;
    localparam int TABLE_DEPTH_DEF = 65536;

    localparam int COUNT_W  = 32;
    localparam int WEIGHT_W = 40;
    localparam int TOTAL_W  = 52;
    localparam int FRAC_W   = 16;
    localparam int CFG_W    = 17;
    localparam int RAND_W   = 64;
    localparam int WORD_W   = 12;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 17'h10000;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 2'd3;

    typedef struct packed {
        logic                req_type;
        logic [COUNT_W-1:0]  word_count;
        logic                last_word;
        logic [RAND_W-1:0]   rand_bits;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]   word_index;
        logic [STATUS_W-1:0] status;
    } out_item_t;

endpackage

/* src/upst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module upst_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [W-1:0]                                wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [W-1:0]                                rd_data
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/upst_weight.sv */
// Iterative count^0.75 unit: two bit-serial square roots and one product.
// Depends on upst_pkg.
module upst_weight (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [upst_pkg::COUNT_W-1:0]   count,
    output logic                           done,
    output logic [upst_pkg::WEIGHT_W-1:0]  weight
);

    typedef enum logic [1:0] {P_IDLE, P_ROOT1, P_ROOT2, P_MUL} phase_t;

    phase_t       phase_reg;
    logic [63:0]  rad_reg;
    logic [31:0]  root_reg;
    logic [34:0]  rem_reg;
    logic [4:0]   step_reg;
    logic [31:0]  s1_reg;
    logic         done_reg;
    logic [upst_pkg::WEIGHT_W-1:0] weight_reg;

    logic [34:0]  rem_sh;
    logic [34:0]  trial;
    logic         fits;
    logic [34:0]  rem_next;
    logic [31:0]  root_next;
    logic [55:0]  prod;

    // One result bit per cycle: bring down two radicand bits, try 4r+1.
    always_comb
    begin
        rem_sh    = {rem_reg[32:0], rad_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        fits      = (rem_sh >= trial);
        rem_next  = fits ? (rem_sh - trial) : rem_sh;
        root_next = {root_reg[30:0], fits};
        prod      = s1_reg * root_reg[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        rad_reg   <= {count, 32'b0};
                        root_reg  <= '0;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        phase_reg <= P_ROOT1;
                    end
                end
                P_ROOT1:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        s1_reg    <= root_next;
                        rad_reg   <= {16'b0, root_next, 16'b0};
                        root_reg  <= '0;
                        rem_reg   <= '0;
                        phase_reg <= P_ROOT2;
                    end
                    else
                    begin
                        rad_reg  <= {rad_reg[61:0], 2'b00};
                        root_reg <= root_next;
                        rem_reg  <= rem_next;
                    end
                end
                P_ROOT2:
                begin
                    rad_reg  <= {rad_reg[61:0], 2'b00};
                    step_reg <= step_reg + 5'd1;
                    root_reg <= root_next;
                    rem_reg  <= rem_next;
                    if (step_reg == 5'd31)
                    begin
                        phase_reg <= P_MUL;
                    end
                end
                P_MUL:
                begin
                    weight_reg <= prod[upst_pkg::FRAC_W +: upst_pkg::WEIGHT_W];
                    done_reg   <= 1'b1;
                    phase_reg  <= P_IDLE;
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign weight = weight_reg;

endmodule

/* src/unigram_power_sampling_table_unit.sv */
// Top level of the unigram power sampling table unit.
// Depends on upst_pkg, upst_ram and upst_weight.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid / in_ready   | upst_pkg::in_item_t  (load, draw)
//  out     | output    | out_valid / out_ready | upst_pkg::out_item_t (index, status)
//  cfg     | input     | cfg_valid / cfg_ready | table_entries, 17 bits
//
// A load transaction without a result completes in the idle state. A draw runs
// the 48-step restoring remainder of (random >> 16) by the built table size
// and then one registered table read. A build first sums the weight of
// every word, then writes one table entry per cycle, pausing at each word
// advance for the next word's weight, which the weight unit (two 32-step
// roots and a product) computes. Reset is asynchronous, active low, and leaves
// no table built; both RAMs are left uninitialized. in_ready is low while an
// item is at work; a finished result waits in the output register, and a
// stalled output holds the next result in the sequencer until it drains.
module unigram_power_sampling_table_unit #(
    parameter int VOCAB_DEPTH = upst_pkg::VOCAB_DEPTH_DEF,
    parameter int TABLE_DEPTH = upst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  upst_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output upst_pkg::out_item_t          out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [upst_pkg::CFG_W-1:0]   cfg_data
);

    localparam int VA   = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
    localparam int TA   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW   = TA + 1;
    localparam int CW   = (EW > upst_pkg::CFG_W) ? EW : upst_pkg::CFG_W;
    localparam int SW   = upst_pkg::WEIGHT_W + VA + 1;
    localparam int TWM  = (SW > upst_pkg::TOTAL_W) ? SW : upst_pkg::TOTAL_W;
    localparam int CMPW = TWM + EW + 1;
    localparam int DIVW = upst_pkg::RAND_W - 16;
    localparam int PW   = upst_pkg::WEIGHT_W + EW;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_DRAW_RD, S_DRAW_DATA,
        S_SUM_RD, S_SUM_ST, S_SUM_W, S_SUM_END,
        S_W_RD, S_W_ST, S_W_W, S_W_ADD, S_WALK, S_RESULT
    } state_t;

    state_t                       state_reg;
    logic [upst_pkg::CFG_W-1:0]   cfg_entries_reg;
    logic [VA:0]                  wl_reg;
    logic                         ovf_reg;
    logic                         built_reg;
    logic [EW-1:0]                built_e_reg;
    logic [VA:0]                  n_reg;
    logic [VA:0]                  wi_reg;
    logic [SW-1:0]                sum_reg;
    logic [upst_pkg::TOTAL_W-1:0] total_reg;
    logic [EW-1:0]                e_reg;
    logic [TA-1:0]                t_reg;
    logic [CMPW-1:0]              lhs_reg;
    logic [CMPW-1:0]              rhs_reg;
    logic [PW-1:0]                we_reg;
    logic [DIVW-1:0]              div_reg;
    logic [EW-1:0]                rem_reg;
    logic [5:0]                   div_cnt_reg;
    upst_pkg::out_item_t          res_reg;
    upst_pkg::out_item_t          out_data_reg;
    logic                         out_valid_reg;

    logic                         accept_in;
    logic                         has_room;
    logic                         ovf_next;
    logic [VA:0]                  wl_next;
    logic                         cnt_we;
    logic                         cnt_re;
    logic [upst_pkg::COUNT_W-1:0] cnt_rdata;
    logic                         tab_we;
    logic                         tab_re;
    logic [VA-1:0]                tab_rdata;
    logic                         w_start;
    logic                         w_done;
    logic [upst_pkg::WEIGHT_W-1:0] w_value;
    logic [EW:0]                  rem_sh;
    logic                         rem_fits;
    logic [EW-1:0]                rem_next;
    logic [CW-1:0]                cfg_ext;
    logic [EW-1:0]                e_clamp;
    logic [upst_pkg::TOTAL_W-1:0] total_next;
    logic                         advance;
    logic                         last_t;

    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        cfg_ready  = 1'b1;
        accept_in  = in_valid && in_ready;
        has_room   = (wl_reg < (VA + 1)'(VOCAB_DEPTH));
        ovf_next   = ovf_reg || !has_room;
        wl_next    = has_room ? (wl_reg + (VA + 1)'(1)) : wl_reg;
        cnt_we     = accept_in && (in_data.req_type == upst_pkg::REQ_LOAD) && has_room;
        cnt_re     = (state_reg == S_SUM_RD) || (state_reg == S_W_RD);
        w_start    = (state_reg == S_SUM_ST) || (state_reg == S_W_ST);
        tab_we     = (state_reg == S_WALK);
        tab_re     = (state_reg == S_DRAW_RD);

        // Restoring remainder step: bring down one dividend bit.
        rem_sh     = {rem_reg, div_reg[DIVW-1]};
        rem_fits   = (rem_sh >= {1'b0, built_e_reg});
        rem_next   = rem_fits ? EW'(rem_sh - {1'b0, built_e_reg}) : EW'(rem_sh);

        // Table size 0 builds one entry; oversize builds the whole RAM.
        cfg_ext    = CW'(cfg_entries_reg);
        if (cfg_ext == '0)
        begin
            e_clamp = EW'(1);
        end
        else if (cfg_ext > CW'(TABLE_DEPTH))
        begin
            e_clamp = EW'(TABLE_DEPTH);
        end
        else
        begin
            e_clamp = EW'(cfg_ext);
        end

        total_next = upst_pkg::TOTAL_W'(sum_reg);
        // t*total > cum*E, both sides kept as running sums.
        advance    = (lhs_reg > rhs_reg) && ((wi_reg + (VA + 1)'(1)) < n_reg);
        last_t     = ((EW'(t_reg) + EW'(1)) == e_reg);
    end

    upst_ram #(
        .W     (upst_pkg::COUNT_W),
        .DEPTH (VOCAB_DEPTH)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (wl_reg[VA-1:0]),
        .wr_data (in_data.word_count),
        .rd_en   (cnt_re),
        .rd_addr (wi_reg[VA-1:0]),
        .rd_data (cnt_rdata)
    );

    upst_ram #(
        .W     (VA),
        .DEPTH (TABLE_DEPTH)
    ) u_table_ram (
        .clk     (clk),
        .wr_en   (tab_we),
        .wr_addr (t_reg),
        .wr_data (wi_reg[VA-1:0]),
        .rd_en   (tab_re),
        .rd_addr (rem_reg[TA-1:0]),
        .rd_data (tab_rdata)
    );

    upst_weight u_weight (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (w_start),
        .count  (cnt_rdata),
        .done   (w_done),
        .weight (w_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cfg_entries_reg <= upst_pkg::CFG_RESET;
            wl_reg          <= '0;
            ovf_reg         <= 1'b0;
            built_reg       <= 1'b0;
            built_e_reg     <= EW'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_entries_reg <= cfg_data;
            end
            // Drop the output once taken, unless a new result lands this cycle.
            if (out_ready && (state_reg != S_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        res_reg.word_index <= '0;
                        if (in_data.req_type == upst_pkg::REQ_DRAW)
                        begin
                            if (!built_reg)
                            begin
                                res_reg.status <= upst_pkg::ST_NOT_BUILT;
                                state_reg      <= S_RESULT;
                            end
                            else
                            begin
                                div_reg     <= in_data.rand_bits[upst_pkg::RAND_W-1:16];
                                rem_reg     <= '0;
                                div_cnt_reg <= 6'(DIVW - 1);
                                state_reg   <= S_DIV;
                            end
                        end
                        else if (!in_data.last_word)
                        begin
                            wl_reg  <= wl_next;
                            ovf_reg <= ovf_next;
                            // Report only loads dropped for lack of room.
                            if (ovf_next)
                            begin
                                res_reg.status <= upst_pkg::ST_TOO_MANY;
                                state_reg      <= S_RESULT;
                            end
                        end
                        else
                        begin
                            // Last word: start a fresh vocabulary afterwards.
                            wl_reg  <= '0;
                            ovf_reg <= 1'b0;
                            if (ovf_next)
                            begin
                                built_reg      <= 1'b0;
                                res_reg.status <= upst_pkg::ST_TOO_MANY;
                                state_reg      <= S_RESULT;
                            end
                            else
                            begin
                                n_reg     <= wl_next;
                                wi_reg    <= '0;
                                sum_reg   <= '0;
                                state_reg <= S_SUM_RD;
                            end
                        end
                    end
                end

                S_DIV:
                begin
                    rem_reg     <= rem_next;
                    div_reg     <= {div_reg[DIVW-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= S_DRAW_RD;
                    end
                end
                S_DRAW_RD:
                begin
                    state_reg <= S_DRAW_DATA;
                end
                S_DRAW_DATA:
                begin
                    res_reg.word_index <= upst_pkg::WORD_W'(tab_rdata);
                    res_reg.status     <= upst_pkg::ST_OK;
                    state_reg          <= S_RESULT;
                end

                // Sum the weights of all loaded words.
                S_SUM_RD:
                begin
                    state_reg <= S_SUM_ST;
                end
                S_SUM_ST:
                begin
                    state_reg <= S_SUM_W;
                end
                S_SUM_W:
                begin
                    if (w_done)
                    begin
                        sum_reg <= sum_reg + SW'(w_value);
                        wi_reg  <= wi_reg + (VA + 1)'(1);
                        if ((wi_reg + (VA + 1)'(1)) == n_reg)
                        begin
                            state_reg <= S_SUM_END;
                        end
                        else
                        begin
                            state_reg <= S_SUM_RD;
                        end
                    end
                end
                S_SUM_END:
                begin
                    total_reg <= total_next;
                    if (total_next == '0)
                    begin
                        built_reg      <= 1'b0;
                        res_reg.status <= upst_pkg::ST_ZERO;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        e_reg     <= e_clamp;
                        lhs_reg   <= '0;
                        rhs_reg   <= '0;
                        t_reg     <= '0;
                        wi_reg    <= '0;
                        state_reg <= S_W_RD;
                    end
                end

                // Fetch the current word's weight and add weight*E to the bound.
                S_W_RD:
                begin
                    state_reg <= S_W_ST;
                end
                S_W_ST:
                begin
                    state_reg <= S_W_W;
                end
                S_W_W:
                begin
                    if (w_done)
                    begin
                        we_reg    <= w_value * e_reg;
                        state_reg <= S_W_ADD;
                    end
                end
                S_W_ADD:
                begin
                    rhs_reg   <= rhs_reg + CMPW'(we_reg);
                    state_reg <= S_WALK;
                end

                // Write one entry per cycle until the word must advance or the last entry is written.
                S_WALK:
                begin
                    lhs_reg <= lhs_reg + CMPW'(total_reg);
                    t_reg   <= t_reg + TA'(1);
                    if (last_t)
                    begin
                        built_e_reg    <= e_reg;
                        built_reg      <= 1'b1;
                        res_reg.status <= upst_pkg::ST_OK;
                        state_reg      <= S_RESULT;
                    end
                    else if (advance)
                    begin
                        wi_reg    <= wi_reg + (VA + 1)'(1);
                        state_reg <= S_W_RD;
                    end
                end

                S_RESULT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_data_reg  <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* tb/unigram_power_sampling_table_unit_test.sv */
// Testbench for the unigram power sampling table unit: load/build/draw checks
// against an in-bench predictor. Depends on upst_pkg and the unit's RTL only.
module unigram_power_sampling_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VOCAB       = 4096;
    localparam int TBL         = 65536;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 300;

    // Predictor of the table unit plus the queue of expected results.
    class sampler_scoreboard;
        logic [31:0]          counts [VOCAB];
        logic [11:0]          sample_tab [TBL];
        int unsigned          n_words;
        bit                   built;
        bit                   overflowed;
        logic [51:0]          total;
        int unsigned          latched_entries;
        logic [16:0]          entries_reg;
        upst_pkg::out_item_t  expected_q [$];
        int                   mismatches;

        function new();
            n_words = 0;
            built = 0;
            overflowed = 0;
            total = '0;
            latched_entries = 1;
            entries_reg = upst_pkg::CFG_RESET;
            mismatches = 0;
        endfunction

        function void set_entries(logic [16:0] v);
            entries_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        static function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // count^0.75 with 16 fraction bits, truncated at each stage
        static function logic [63:0] pow_weight(logic [31:0] c);
            logic [63:0] s1;
            logic [63:0] s2;
            s1 = int_sqrt({c, 32'h0});
            s2 = int_sqrt(s1 << 16);
            return (s1 * s2) >> 16;
        endfunction

        function logic [1:0] build_sampling_table();
            logic [63:0]  sum;
            logic [63:0]  cum;
            logic [127:0] lhs;
            logic [127:0] rhs;
            int unsigned  e;
            int unsigned  idx;
            sum = 0;
            for (int i = 0; i < n_words; i++)
                sum += pow_weight(counts[i]);
            total = sum[51:0];
            if (total == 0)
            begin
                built = 0;
                return upst_pkg::ST_ZERO;
            end
            e = entries_reg;
            if (e == 0)
                e = 1;
            if (e > TBL)
                e = TBL;
            idx = 0;
            cum = pow_weight(counts[0]);
            for (int unsigned t = 0; t < e; t++)
            begin
                sample_tab[t] = idx[11:0];
                lhs = 128'(t) * 128'(total);
                rhs = 128'(cum) * 128'(e);
                if (lhs > rhs && idx + 1 < n_words)
                begin
                    idx++;
                    cum += pow_weight(counts[idx]);
                end
            end
            latched_entries = e;
            built = 1;
            return upst_pkg::ST_OK;
        endfunction

        function void note_item(upst_pkg::in_item_t it);
            upst_pkg::out_item_t res;
            logic [63:0]         pos;
            res.word_index = '0;
            if (it.req_type == upst_pkg::REQ_DRAW)
            begin
                if (!built)
                    res.status = upst_pkg::ST_NOT_BUILT;
                else
                begin
                    pos = (it.rand_bits >> 16) % 64'(latched_entries);
                    res.word_index = sample_tab[pos];
                    res.status = upst_pkg::ST_OK;
                end
                expected_q.push_back(res);
                return;
            end
            if (n_words < VOCAB)
            begin
                counts[n_words] = it.word_count;
                n_words++;
            end
            else
                overflowed = 1;
            if (!it.last_word)
            begin
                if (n_words >= VOCAB && overflowed)
                begin
                    res.status = upst_pkg::ST_TOO_MANY;
                    expected_q.push_back(res);
                end
                return;
            end
            if (overflowed)
            begin
                built = 0;
                res.status = upst_pkg::ST_TOO_MANY;
            end
            else
                res.status = build_sampling_table();
            n_words = 0;
            overflowed = 0;
            expected_q.push_back(res);
        endfunction

        function void check_result(upst_pkg::out_item_t got);
            upst_pkg::out_item_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d status %0d",
                             got.word_index, got.status);
                return;
            end
            want = expected_q.pop_front();
            if (got.word_index !== want.word_index || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected index %0d status %0d, ",
                              "got index %0d status %0d"},
                             want.word_index, want.status,
                             got.word_index, got.status);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    upst_pkg::in_item_t   in_data;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    upst_pkg::out_item_t  out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [16:0]          cfg_data;

    sampler_scoreboard sb;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          stall_request = 1'b0;
    bit          stall_taken = 1'b0;
    int          stall_left = 0;
    int unsigned cycle_count = 0;
    int          items_sent;

    unigram_power_sampling_table_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request so the
    // unit fills its output register and sequencer and drops in_ready.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_request && !stall_taken)
        begin
            stall_taken <= 1'b1;
            stall_left <= 400;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every result transaction at the rising edge it completes on.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    function automatic upst_pkg::in_item_t load_item(logic [31:0] c, logic last);
        upst_pkg::in_item_t it;
        it.req_type = upst_pkg::REQ_LOAD;
        it.word_count = c;
        it.last_word = last;
        it.rand_bits = {$urandom, $urandom};
        return it;
    endfunction

    function automatic upst_pkg::in_item_t draw_item(logic [63:0] r);
        upst_pkg::in_item_t it;
        it.req_type = upst_pkg::REQ_DRAW;
        it.word_count = $urandom;
        it.last_word = 1'($urandom_range(0, 1));
        it.rand_bits = r;
        return it;
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    // Offer one transaction; called and returning at a falling edge. Valid is
    // left high so the next item follows back to back unless the sender idles.
    task automatic send(input upst_pkg::in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    // Drain all results, let the unit settle, then write table_entries.
    task automatic write_entries(input logic [16:0] v);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_entries(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly whole vocabularies followed by draws; some stray draws in the
    // middle of a load sequence and some table resizes between vocabularies.
    task automatic run_random(input int target);
        int stop_at;
        int n;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    write_entries($urandom_range(0, 1) ? 17'd0 : 17'd1);
                else
                    write_entries(17'($urandom_range(1, 300)));
            end
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send(draw_item({$urandom, $urandom}));
                send(load_item(pick_count(), i == n - 1));
            end
            n = $urandom_range(5, 30);
            for (int i = 0; i < n; i++)
                send(draw_item({$urandom, $urandom}));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        items_sent = 0;
        send_idle_pct = 20;
        recv_idle_pct = 56;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: draw with no table, full-size table at the reset setting,
        // extreme counts and random values, all-zero weights, small sizes.
        send(draw_item(64'h0));
        send(load_item(32'd1, 1'b0));
        send(load_item(32'hFFFF_FFFF, 1'b0));
        send(load_item(32'd0, 1'b0));
        send(load_item(32'd7, 1'b1));
        send(draw_item(64'h0));
        send(draw_item(64'hFFFF_FFFF_FFFF_FFFF));
        send(draw_item(64'h0000_0000_0000_FFFF));
        write_entries(17'h1FFFF);
        send(load_item(32'd5, 1'b0));
        send(load_item(32'd100, 1'b1));
        write_entries(17'd3);
        send(draw_item(64'hFFFF_FFFF_FFFF_0000));
        send(load_item(32'd0, 1'b0));
        send(load_item(32'd0, 1'b1));
        send(draw_item(64'h1234_5678_9ABC_DEF0));
        write_entries(17'd0);
        send(load_item(32'd2, 1'b0));
        send(load_item(32'd9, 1'b1));
        send(draw_item(64'hFFFF_FFFF_FFFF_FFFF));
        write_entries(17'd1);
        send(load_item(32'd3, 1'b1));
        // the latched size is kept after a register write
        write_entries(17'd200);
        send(draw_item(64'h0));
        run_random(410);

        send_idle_pct = 56;
        recv_idle_pct = 20;
        run_random(410);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Full-size table over a short vocabulary, then back-to-back draws.
        write_entries(17'd65536);
        for (int i = 0; i < 40; i++)
            send(load_item($urandom_range(1000, 1100), i == 39));
        for (int i = 0; i < 40; i++)
            send(draw_item({$urandom, $urandom}));
        write_entries(17'd64);
        stall_request <= 1'b1;
        run_random(410);

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
